FILE: rtl/s5fc_pkg.sv
// ----------------------------------------------------------------------------
// s5fc_pkg
// Shared types, constants and round functions of the SHA-512 family
// compression unit.
// ----------------------------------------------------------------------------
package s5fc_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned Rounds  = 80;
  localparam int unsigned BlkWords = 16;
  localparam int unsigned RndW    = $clog2(Rounds);
  localparam int unsigned IdxW    = $clog2(BlkWords);

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [1:0] {
    VAR_SHA512     = 2'd0,
    VAR_SHA384     = 2'd1,
    VAR_SHA512_256 = 2'd2,
    VAR_SHA512_224 = 2'd3
  } variant_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SETUP,
    ST_ROUND,
    ST_UPDATE
  } state_e;

  // Controls of the message schedule row.
  typedef struct packed {
    logic shift_in;
    logic step;
  } sched_ctl_t;

  // Controls of the working state row.
  typedef struct packed {
    logic            setup;
    logic            step;
    logic [RndW-1:0] k_idx;
  } rnd_ctl_t;

  localparam word_t RoundK [Rounds] = '{
    64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
    64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
    64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
    64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
    64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
    64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
    64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
    64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
    64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
    64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
    64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
    64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
    64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
    64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
    64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
    64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
    64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
    64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
    64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
    64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
  };

  localparam word_t InitVal [4][8] = '{
    '{64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
      64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F, 64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179},
    '{64'hCBBB9D5DC1059ED8, 64'h629A292A367CD507, 64'h9159015A3070DD17, 64'h152FECD8F70E5939,
      64'h67332667FFC00B31, 64'h8EB44A8768581511, 64'hDB0C2E0D64F98FA7, 64'h47B5481DBEFA4FA4},
    '{64'h22312194FC2BF72C, 64'h9F555FA3C84C64C2, 64'h2393B86B6F53B151, 64'h963877195940EABD,
      64'h96283EE2A88EFFE3, 64'hBE5E1E2553863992, 64'h2B0199FC2C85B8AA, 64'h0EB72DDC81C52CA2},
    '{64'h8C3D37C819544DA2, 64'h73E1996689DCD4D6, 64'h1DFAB7AE32FF9C82, 64'h679DD514582F9FCF,
      64'h0F6D2B697BD44DA8, 64'h77E36F7304C48942, 64'h3F9D85A86A1D36C8, 64'h1112E6AD91D692A1}
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

  // Number of digest words for each variant.
  function automatic logic [3:0] digest_len(input variant_e v);
    logic [3:0] n;
    case (v)
      VAR_SHA512:     n = 4'd8;
      VAR_SHA384:     n = 4'd6;
      VAR_SHA512_256: n = 4'd4;
      VAR_SHA512_224: n = 4'd4;
      default:        n = 4'd8;
    endcase
    return n;
  endfunction

endpackage

FILE: rtl/s5fc_if.sv
// ----------------------------------------------------------------------------
// s5fc_if
// Valid/ready channels of the compression unit: message words in,
// digest words out.
// ----------------------------------------------------------------------------
interface s5fc_msg_if
  import s5fc_pkg::*;
();
  logic  valid;
  logic  ready;
  word_t msg_word;
  logic  new_message;
  logic  final_block;

  modport source(output valid, msg_word, new_message, final_block, input ready);
  modport sink(input valid, msg_word, new_message, final_block, output ready);
endinterface

interface s5fc_dig_if
  import s5fc_pkg::*;
();
  logic       valid;
  logic       ready;
  word_t      digest_word;
  logic [3:0] digest_bytes;
  logic       last_word;

  modport source(output valid, digest_word, digest_bytes, last_word, input ready);
  modport sink(input valid, digest_word, digest_bytes, last_word, output ready);
endinterface

FILE: rtl/s5fc_cell.sv
// ----------------------------------------------------------------------------
// s5fc_cell
// One 64-bit cell of a row: takes its neighbor's word or a loaded word.
// ----------------------------------------------------------------------------
module s5fc_cell
  import s5fc_pkg::*;
(
  input  logic  clk_i,
  input  logic  en_i,
  input  logic  sel_ld_i,
  input  word_t ld_val_i,
  input  word_t nbr_val_i,
  output word_t q_o
);

  word_t q_q;
  word_t q_d;

  assign q_d = sel_ld_i ? ld_val_i : nbr_val_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

FILE: rtl/s5fc_sched.sv
// ----------------------------------------------------------------------------
// s5fc_sched
// Message schedule: a row of sixteen cells. Message words shift in at the
// tail; during the rounds each step shifts out W[t] and appends W[t+16].
// ----------------------------------------------------------------------------
module s5fc_sched
  import s5fc_pkg::*;
(
  input  logic       clk_i,
  input  sched_ctl_t ctl_i,
  input  word_t      word_i,
  output word_t      w0_o,
  output word_t      w1_o
);

  word_t w [BlkWords];
  word_t w_new;
  word_t tail_in;

  // W[t+16] from the window that starts at W[t].
  assign w_new = small_sigma1(w[BlkWords-2]) + w[9] + small_sigma0(w[1]) + w[0];
  assign tail_in = ctl_i.shift_in ? word_i : w_new;

  for (genvar i = 0; i < BlkWords; i++) begin : g_row
    s5fc_cell u_wc (
      .clk_i    (clk_i),
      .en_i     (ctl_i.shift_in | ctl_i.step),
      .sel_ld_i (i == BlkWords - 1),
      .ld_val_i (tail_in),
      .nbr_val_i(w[(i + 1) % BlkWords]),
      .q_o      (w[i])
    );
  end

  assign w0_o = w[0];
  assign w1_o = w[1];

endmodule

FILE: rtl/s5fc_round.sv
// ----------------------------------------------------------------------------
// s5fc_round
// Working state a..h as a row of eight cells, one round per step. The sum
// h + K + W of the coming round is registered in the cycle before it.
// ----------------------------------------------------------------------------
module s5fc_round
  import s5fc_pkg::*;
(
  input  logic     clk_i,
  input  rnd_ctl_t ctl_i,
  input  word_t    chain_i [8],
  input  word_t    w_i,
  output word_t    work_o [8]
);

  word_t v [8];
  word_t hkw_q;
  word_t hkw_d;
  word_t t1;
  word_t t2;
  word_t ld_val [8];

  assign t1 = hkw_q + big_sigma1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]));
  assign t2 = big_sigma0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  // h of the next round is g of this one.
  assign hkw_d = (ctl_i.setup ? chain_i[7] : v[6]) + RoundK[ctl_i.k_idx] + w_i;

  always_ff @(posedge clk_i) begin
    if (ctl_i.setup | ctl_i.step) begin
      hkw_q <= hkw_d;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      ld_val[i] = chain_i[i];
    end
    if (!ctl_i.setup) begin
      ld_val[0] = t1 + t2;
      ld_val[4] = v[3] + t1;
    end
  end

  for (genvar i = 0; i < 8; i++) begin : g_row
    s5fc_cell u_vc (
      .clk_i    (clk_i),
      .en_i     (ctl_i.setup | ctl_i.step),
      .sel_ld_i (ctl_i.setup | (i == 0) | (i == 4)),
      .ld_val_i (ld_val[i]),
      .nbr_val_i(v[(i + 7) % 8]),
      .q_o      (v[i])
    );
    assign work_o[i] = v[i];
  end

endmodule

FILE: rtl/sha512_family_compression_unit.sv
// ----------------------------------------------------------------------------
// sha512_family_compression_unit
// SHA-512 / SHA-384 / SHA-512/256 / SHA-512/224 compression of padded
// 1024-bit blocks with truncated digest output.
// ----------------------------------------------------------------------------
// Sequence: after the sixteenth word transfer of a block come a setup
// state, the rounds and a chain update; the update of a final block waits
// until the previous digest has been transferred. The first digest word is
// offered in the cycle after the update. Words are taken only in the load
// state, after the single round row (one round per cycle) is done.
// Reset: asynchronous, active low; clears the chain to zero, the variant
// to SHA-512, the word index and all control state.
// ----------------------------------------------------------------------------
module sha512_family_compression_unit
  import s5fc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_wdata_i,
  s5fc_msg_if.sink          msg_i,
  s5fc_dig_if.source        dig_o
);

  // Configuration register.
  variant_e var_q;

  // Control state.
  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q;
  logic [RndW-1:0] rnd_q;
  logic            fin_q;

  // Chain value and the digest output row.
  word_t      chain_q [8];
  word_t      dig_q [8];
  logic [3:0] emit_cnt_q;
  variant_e   emit_var_q;

  word_t      work [8];
  word_t      chain_sum [8];
  word_t      w0;
  word_t      w1;
  sched_ctl_t sched_ctl;
  rnd_ctl_t   rnd_ctl;

  logic            msg_xfer;
  logic            dig_xfer;
  logic [IdxW-1:0] eff_idx;
  logic            blk_done;
  logic            upd_go;
  logic            emit_last;

  assign msg_xfer = msg_i.valid & msg_i.ready;
  assign dig_xfer = dig_o.valid & dig_o.ready;

  // A new message restarts the block at word zero.
  assign eff_idx  = msg_i.new_message ? '0 : idx_q;
  assign blk_done = msg_xfer & (eff_idx == IdxW'(BlkWords - 1));

  // A final block waits in the update state until the previous digest has
  // been fully transferred, since the digest row holds only one digest.
  assign upd_go = !(fin_q && (emit_cnt_q != 4'd0));

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      chain_sum[i] = chain_q[i] + work[i];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (blk_done) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: state_d = ST_ROUND;
      ST_ROUND: begin
        if (rnd_q == RndW'(Rounds - 1)) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (upd_go) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    msg_i.ready        = 1'b0;
    sched_ctl.shift_in = 1'b0;
    sched_ctl.step     = 1'b0;
    rnd_ctl.setup      = 1'b0;
    rnd_ctl.step       = 1'b0;
    rnd_ctl.k_idx      = '0;
    case (state_q)
      ST_LOAD: begin
        msg_i.ready        = 1'b1;
        sched_ctl.shift_in = msg_xfer;
      end
      ST_SETUP: begin
        rnd_ctl.setup = 1'b1;
      end
      ST_ROUND: begin
        sched_ctl.step = 1'b1;
        rnd_ctl.step   = 1'b1;
        // Constant index of the following round; unused after the last one.
        rnd_ctl.k_idx  = (rnd_q == RndW'(Rounds - 1)) ? '0 : rnd_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  s5fc_sched u_sched (
    .clk_i (clk_i),
    .ctl_i (sched_ctl),
    .word_i(msg_i.msg_word),
    .w0_o  (w0),
    .w1_o  (w1)
  );

  // The setup cycle prepares round 0 from W[0]; each round prepares the
  // next one from W[t+1], which sits one cell up in the schedule row.
  s5fc_round u_round (
    .clk_i  (clk_i),
    .ctl_i  (rnd_ctl),
    .chain_i(chain_q),
    .w_i    (rnd_ctl.setup ? w0 : w1),
    .work_o (work)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_q      <= VAR_SHA512;
      state_q    <= ST_LOAD;
      idx_q      <= '0;
      rnd_q      <= '0;
      fin_q      <= 1'b0;
      emit_cnt_q <= '0;
      emit_var_q <= VAR_SHA512;
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        var_q <= variant_e'(cfg_wdata_i);
      end

      if (msg_xfer) begin
        if (msg_i.new_message) begin
          for (int i = 0; i < 8; i++) begin
            chain_q[i] <= InitVal[var_q][i];
          end
        end
        idx_q <= eff_idx + 1'b1;
        fin_q <= msg_i.final_block;
      end

      if (state_q == ST_SETUP) begin
        rnd_q <= '0;
      end else if (state_q == ST_ROUND) begin
        rnd_q <= rnd_q + 1'b1;
      end

      if (state_q == ST_UPDATE && upd_go) begin
        for (int i = 0; i < 8; i++) begin
          chain_q[i] <= chain_sum[i];
        end
      end

      // A digest word may leave while a non-final block updates the chain.
      if (state_q == ST_UPDATE && upd_go && fin_q) begin
        emit_cnt_q <= digest_len(var_q);
        emit_var_q <= var_q;
      end else if (dig_xfer) begin
        emit_cnt_q <= emit_cnt_q - 1'b1;
      end
    end
  end

  // Digest row: loaded on a final update, shifts one word per transfer.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPDATE && upd_go && fin_q) begin
      for (int i = 0; i < 8; i++) begin
        dig_q[i] <= chain_sum[i];
      end
    end else if (dig_xfer) begin
      for (int i = 0; i < 7; i++) begin
        dig_q[i] <= dig_q[i + 1];
      end
    end
  end

  // The last SHA-512/224 word carries only its upper half.
  assign emit_last         = (emit_cnt_q == 4'd1);
  assign dig_o.valid       = (emit_cnt_q != 4'd0);
  assign dig_o.last_word   = emit_last;
  assign dig_o.digest_word = (emit_last && emit_var_q == VAR_SHA512_224)
                             ? {dig_q[0][WordW-1:WordW/2], {(WordW/2){1'b0}}}
                             : dig_q[0];
  assign dig_o.digest_bytes = (emit_last && emit_var_q == VAR_SHA512_224) ? 4'd4 : 4'd8;

endmodule
